/* src/tfcd_pkg.sv */
`default_nettype none

package tfcd_pkg;

  // Configuration port geometry
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_TIMEOUT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_HANDLER = 2'd1;

  // Register reset values
  localparam logic [15:0] CLOSE_TIMEOUT_RESET = 16'd60;

  // Command codes reported on the result channel
  localparam logic [3:0] CMD_UNKNOWN     = 4'd0;
  localparam logic [3:0] CMD_PAUSE       = 4'd1;
  localparam logic [3:0] CMD_ON          = 4'd2;
  localparam logic [3:0] CMD_OFF         = 4'd3;
  localparam logic [3:0] CMD_SELECT_BOT  = 4'd4;
  localparam logic [3:0] CMD_BOT_REJECT  = 4'd5;
  localparam logic [3:0] CMD_SET_PAYLOAD = 4'd6;
  localparam logic [3:0] CMD_SET_IGNORED = 4'd7;
  localparam logic [3:0] CMD_RESET       = 4'd8;

  // Command patterns, matched by prefix in index order
  localparam int NumPat   = 6;
  localparam int PAT_IX_PAUSE = 0;
  localparam int PAT_IX_ON    = 1;
  localparam int PAT_IX_OFF   = 2;
  localparam int PAT_IX_BOT   = 3;
  localparam int PAT_IX_SET   = 4;
  localparam int PAT_IX_RESET = 5;

  // Byte 0 of a pattern sits in element 0 (rightmost in the concatenation)
  typedef logic [7:0][7:0] pat_t;

  localparam pat_t PAT_TBL [NumPat] = '{
    {8'h00, 8'h00, 8'h00, "E", "S", "U", "A", "P"},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "N", "O"},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "F", "F", "O"},
    {8'h00, 8'h00, 8'h00, 8'h00, "=", "T", "O", "B"},
    {8'h00, 8'h00, 8'h00, 8'h00, "=", "T", "E", "S"},
    {8'h00, 8'h00, 8'h00, "T", "E", "S", "E", "R"}
  };

  localparam logic [2:0] PAT_LEN [NumPat] = '{3'd5, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5};

  // Position of the bot letter after "BOT="
  localparam logic [2:0] BOT_BYTE_POS = 3'd4;
  localparam logic [7:0] BOT_BASE     = "a";

  typedef struct packed {
    logic        byte_present;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] command_code;
    logic [4:0] bot_index;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PAY_RD,
    ST_PAY_OUT
  } state_e;

endpackage

`default_nettype wire

/* src/tfcd_frame_ram.sv */
`default_nettype none

module tfcd_frame_ram #(
  parameter int Depth = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/timeout_framed_command_decoder_core.sv */
`default_nettype none

// Timeout-framed command decoder. Each input item is one poll with an optional
// received byte and the current millisecond time. One poll is taken per clock
// cycle while the result register is free; a result that waits unaccepted
// holds off the next poll. The first byte opens a frame, and up to FRAME_BYTES
// bytes go into a frame memory (later bytes are dropped). Once close_timeout_ms
// have passed since the first byte (32-bit wrapping difference) the frame
// closes, the byte of that poll included, and is matched by prefix against
// PAUSE, ON, OFF, BOT=, SET= and RESET. Prefix matches and the bot letter are
// tracked as the bytes arrive, so every command but a SET= payload run gives
// its single result in the poll that closes the frame. A SET= run with a
// payload consumer reads the payload bytes back from the frame memory, each
// byte read and then loaded into the output register, and takes no poll
// until the last byte is loaded; an output stall holds the run. The memory
// needs no clearing after reset.
module timeout_framed_command_decoder_core #(
  parameter int FRAME_BYTES   = 25,
  parameter int MAX_BOT_INDEX = 15
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tfcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tfcd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire tfcd_pkg::in_item_t            in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      tfcd_pkg::out_item_t           out_data_o
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam logic [LW-1:0] LenMax   = LW'(FRAME_BYTES);
  localparam logic [LW-1:0] PayStart = LW'(tfcd_pkg::PAT_LEN[tfcd_pkg::PAT_IX_SET]);
  localparam logic [7:0]    BotMax   = 8'(MAX_BOT_INDEX);

  // Configuration registers
  logic [15:0] timeout_q;
  logic        handler_q;

  // Frame state and control
  tfcd_pkg::state_e state_q, state_d;
  logic [LW-1:0]               len_q, len_d;
  logic                        open_q, open_d;
  logic [31:0]                 start_q, start_d;
  logic [tfcd_pkg::NumPat-1:0] ok_q, ok_d, hit;
  logic [7:0]                  bot_byte_q, bot_byte_d;
  logic [AW-1:0]               rd_ptr_q;
  logic                        out_valid_q;
  tfcd_pkg::out_item_t         out_q, res;

  logic        out_free, accept, store, close_now, pay_run, pay_last;
  logic        load_out, clear_frame, rd_en;
  logic [31:0] elapsed;
  logic [7:0]  bot_diff;
  logic        bot_ok;
  logic [7:0]  rd_data;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tfcd_pkg::CLOSE_TIMEOUT_RESET;
      handler_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tfcd_pkg::CFG_CLOSE_TIMEOUT) begin
        timeout_q <= cfg_data_i[15:0];
      end else if (cfg_index_i == tfcd_pkg::CFG_PAYLOAD_HANDLER) begin
        handler_q <= cfg_data_i[0];
      end
    end
  end

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == tfcd_pkg::ST_RUN) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && in_data_i.byte_present && (len_q < LenMax);

  // Frame update for this poll
  assign len_d      = store ? len_q + LW'(1) : len_q;
  assign open_d     = open_q || store;
  assign start_d    = open_q ? start_q : in_data_i.now_ms;
  assign elapsed    = in_data_i.now_ms - start_d;
  assign close_now  = accept && open_d && (elapsed >= {16'd0, timeout_q});
  assign bot_byte_d = (store && len_q == LW'(tfcd_pkg::BOT_BYTE_POS)) ?
                      in_data_i.rx_byte : bot_byte_q;

  // Track each pattern's prefix match as bytes arrive
  always_comb begin
    for (int p = 0; p < tfcd_pkg::NumPat; p++) begin
      ok_d[p] = ok_q[p];
      if (store && len_q < LW'(tfcd_pkg::PAT_LEN[p])) begin
        ok_d[p] = ok_q[p] &&
                  (in_data_i.rx_byte == tfcd_pkg::PAT_TBL[p][len_q[2:0]]);
      end
      hit[p] = ok_d[p] && (len_d >= LW'(tfcd_pkg::PAT_LEN[p]));
    end
  end

  // Bot letter check
  assign bot_diff = bot_byte_d - tfcd_pkg::BOT_BASE;
  assign bot_ok   = (len_d > LW'(tfcd_pkg::BOT_BYTE_POS)) &&
                    (bot_byte_d >= tfcd_pkg::BOT_BASE) && (bot_diff <= BotMax);

  // Payload run bookkeeping
  assign pay_last = ((LW'(rd_ptr_q) + LW'(1)) == len_q);
  assign pay_run  = !hit[tfcd_pkg::PAT_IX_PAUSE] && !hit[tfcd_pkg::PAT_IX_ON] &&
                    !hit[tfcd_pkg::PAT_IX_OFF] && !hit[tfcd_pkg::PAT_IX_BOT] &&
                    hit[tfcd_pkg::PAT_IX_SET] && handler_q && (len_d > PayStart);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfcd_pkg::ST_RUN: begin
        if (close_now && pay_run) begin
          state_d = tfcd_pkg::ST_PAY_RD;
        end
      end
      tfcd_pkg::ST_PAY_RD: begin
        state_d = tfcd_pkg::ST_PAY_OUT;
      end
      tfcd_pkg::ST_PAY_OUT: begin
        if (out_free) begin
          state_d = pay_last ? tfcd_pkg::ST_RUN : tfcd_pkg::ST_PAY_RD;
        end
      end
      default: state_d = tfcd_pkg::ST_RUN;
    endcase
  end

  // Outputs of the state machine: result selection and strobes
  always_comb begin
    res          = '0;
    res.last_of_run = 1'b1;
    load_out     = 1'b0;
    clear_frame  = 1'b0;
    rd_en        = 1'b0;
    unique case (state_q)
      tfcd_pkg::ST_RUN: begin
        priority if (hit[tfcd_pkg::PAT_IX_PAUSE]) begin
          res.command_code = tfcd_pkg::CMD_PAUSE;
        end else if (hit[tfcd_pkg::PAT_IX_ON]) begin
          res.command_code = tfcd_pkg::CMD_ON;
        end else if (hit[tfcd_pkg::PAT_IX_OFF]) begin
          res.command_code = tfcd_pkg::CMD_OFF;
        end else if (hit[tfcd_pkg::PAT_IX_BOT]) begin
          if (bot_ok) begin
            res.command_code = tfcd_pkg::CMD_SELECT_BOT;
            res.bot_index    = bot_diff[4:0];
          end else begin
            res.command_code = tfcd_pkg::CMD_BOT_REJECT;
          end
        end else if (hit[tfcd_pkg::PAT_IX_SET]) begin
          res.command_code = handler_q ? tfcd_pkg::CMD_SET_PAYLOAD :
                                         tfcd_pkg::CMD_SET_IGNORED;
        end else if (hit[tfcd_pkg::PAT_IX_RESET]) begin
          res.command_code = tfcd_pkg::CMD_RESET;
        end else begin
          res.command_code = tfcd_pkg::CMD_UNKNOWN;
        end
        load_out    = close_now && !pay_run;
        clear_frame = close_now && !pay_run;
      end
      tfcd_pkg::ST_PAY_RD: begin
        rd_en = 1'b1;
      end
      tfcd_pkg::ST_PAY_OUT: begin
        res.command_code  = tfcd_pkg::CMD_SET_PAYLOAD;
        res.payload_byte  = rd_data;
        res.payload_valid = 1'b1;
        res.last_of_run   = pay_last;
        load_out          = out_free;
        clear_frame       = out_free && pay_last;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfcd_pkg::ST_RUN;
      len_q       <= '0;
      open_q      <= 1'b0;
      start_q     <= '0;
      ok_q        <= '1;
      out_valid_q <= 1'b0;
      rd_ptr_q    <= '0;
    end else begin
      state_q <= state_d;
      // Drop the frame once its last result is loaded
      if (clear_frame) begin
        len_q  <= '0;
        open_q <= 1'b0;
        ok_q   <= '1;
      end else if (accept) begin
        len_q   <= len_d;
        open_q  <= open_d;
        start_q <= start_d;
        ok_q    <= ok_d;
      end
      // Advance the payload read pointer
      if (close_now && pay_run) begin
        rd_ptr_q <= AW'(PayStart);
      end else if (state_q == tfcd_pkg::ST_PAY_OUT && out_free && !pay_last) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      // Output register valid
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bot_byte_q <= bot_byte_d;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  tfcd_frame_ram #(
    .Depth (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (in_data_i.rx_byte),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Frame length stays within the memory
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("frame length beyond frame memory");

  // Open flag agrees with a nonempty frame
  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (len_q != '0))
    else $error("open flag and frame length disagree");

  // Payload reads stay inside the stored frame
  a_rd_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tfcd_pkg::ST_RUN) |-> (LW'(rd_ptr_q) < len_q))
    else $error("payload read beyond frame length");

  // Last payload byte loaded clears the frame and resumes polling
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfcd_pkg::ST_PAY_OUT && out_free && pay_last) |=>
    (len_q == '0 && state_q == tfcd_pkg::ST_RUN && out_valid_q))
    else $error("payload run did not end cleanly");

endmodule

`default_nettype wire
